[sv/cls_pkg.sv]
`default_nettype none

package cls_pkg;

  localparam logic [2:0] MODE_WAIT    = 3'd0;
  localparam logic [2:0] MODE_DISPLAY = 3'd1;
  localparam logic [2:0] MODE_SPOOL   = 3'd2;
  localparam logic [2:0] MODE_DOWN    = 3'd3;
  localparam logic [2:0] MODE_UP      = 3'd4;

  localparam logic [1:0] PORT_NONE  = 2'd0;
  localparam logic [1:0] PORT_SPOOL = 2'd1;
  localparam logic [1:0] PORT_BLADE = 2'd2;

  localparam logic [1:0] REG_LENGTH_SCALE = 2'd0;
  localparam logic [1:0] REG_DOWN_STEPS   = 2'd1;
  localparam logic [1:0] REG_UP_STEPS     = 2'd2;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [7:0] LENGTH_SCALE_RST = 8'd35;
  localparam logic [7:0] DOWN_STEPS_RST   = 8'd40;
  localparam logic [7:0] UP_STEPS_RST     = 8'd30;

  localparam logic [7:0] SPOOL_PAT_A = 8'h3D;
  localparam logic [7:0] SPOOL_PAT_B = 8'h34;

  localparam int LEN_W = 20;

  typedef logic [LEN_W-1:0] len_t;

  // half-step coil sequence, forward order
  function automatic logic [7:0] blade_pattern(input logic [2:0] idx);
    logic [7:0] pat;
    case (idx)
      3'd0: pat = 8'h01;
      3'd1: pat = 8'h03;
      3'd2: pat = 8'h02;
      3'd3: pat = 8'h06;
      3'd4: pat = 8'h04;
      3'd5: pat = 8'h0C;
      3'd6: pat = 8'h08;
      3'd7: pat = 8'h09;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[sv/cut_length_stepper_sequencer.sv]
`default_nettype none

// Cut-length stepper sequencer.
// Input channel (in_valid/in_stall, key_code): one word per timer tick,
// key_code = 0 when no key is pressed. Output channel (out_valid/out_stall):
// the words caused by that tick, with last set on the final one.
// Words per tick: 1 in wait or display, 2 in spool, 8 in blade down/up.
// The first result word is presented on the cycle after accept;
// a '*' commit in wait first runs a shift-add multiply of the
// entered length by length_scale on one 20-bit adder, so its word
// appears only once the multiply is done.
// One tick occupies the block until its last word is taken; its
// words go out one per cycle while the receiver does not stall.
// in_stall is high while a tick is being worked on or emitted.
// When out_stall is high the current word holds and the sequence pauses.
// Configuration (cfg_write, cfg_index, cfg_data) writes length_scale,
// down_steps and up_steps; write only while idle. Index 3 is ignored.
// Synchronous reset: mode wait, digits cleared to '0', counters zero,
// registers back to 35 / 40 / 30, no word pending.

module cut_length_stepper_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] key_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      drive_port,
  output logic [7:0]      drive_pattern,
  output logic            show_display,
  output logic [1:0]      shown_count,
  output logic [7:0]      shown_first,
  output logic [7:0]      shown_second,
  output logic [2:0]      mode_now,
  output logic            last
);
  import cls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [7:0] length_scale;
  logic [7:0] down_steps;
  logic [7:0] up_steps;

  logic [2:0] mode;
  logic [2:0] cur_mode;
  logic [7:0] digit0;
  logic [7:0] digit1;
  logic [1:0] digit_count;
  len_t       target_length;
  len_t       spool_count;
  logic [7:0] step_count;
  logic [2:0] idx;

  len_t       mul_a;
  len_t       mul_acc;
  logic [7:0] mul_b;
  logic [2:0] mul_cnt;

  len_t       acc_next;
  len_t       spool_next;
  logic [7:0] step_next;
  logic [7:0] tens;
  logic [7:0] ones;
  len_t       entry_value;
  logic [2:0] last_idx;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  assign acc_next   = mul_acc + (mul_b[0] ? mul_a : '0);
  assign spool_next = spool_count + len_t'(1);
  assign step_next  = step_count + 8'd1;
  assign tens       = digit0 - CHAR_ZERO;
  assign ones       = digit1 - CHAR_ZERO;
  assign entry_value = (len_t'(tens) << 3) + (len_t'(tens) << 1) + len_t'(ones);

  always_comb begin
    case (cur_mode)
      MODE_SPOOL: last_idx = 3'd1;
      MODE_DOWN,
      MODE_UP:    last_idx = 3'd7;
      default:    last_idx = 3'd0;
    endcase
  end

  // result word, built from registers so it holds under stall
  always_comb begin
    drive_port    = PORT_NONE;
    drive_pattern = 8'h00;
    show_display  = 1'b0;
    case (cur_mode)
      MODE_DISPLAY: show_display = 1'b1;
      MODE_SPOOL: begin
        drive_port    = PORT_SPOOL;
        drive_pattern = (idx[0] == 1'b0) ? SPOOL_PAT_A : SPOOL_PAT_B;
      end
      MODE_DOWN: begin
        drive_port    = PORT_BLADE;
        drive_pattern = blade_pattern(idx);
      end
      MODE_UP: begin
        drive_port    = PORT_BLADE;
        drive_pattern = blade_pattern(~idx);
      end
      default: begin
        drive_port    = PORT_NONE;
        drive_pattern = 8'h00;
      end
    endcase
    shown_count  = show_display ? digit_count : 2'd0;
    shown_first  = show_display ? digit0 : 8'h00;
    shown_second = show_display ? digit1 : 8'h00;
  end

  assign mode_now = mode;
  assign last     = (idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      length_scale <= LENGTH_SCALE_RST;
      down_steps   <= DOWN_STEPS_RST;
      up_steps     <= UP_STEPS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LENGTH_SCALE: length_scale <= cfg_data;
        REG_DOWN_STEPS:   down_steps   <= cfg_data;
        REG_UP_STEPS:     up_steps     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_WAIT;
      cur_mode      <= MODE_WAIT;
      digit0        <= CHAR_ZERO;
      digit1        <= CHAR_ZERO;
      digit_count   <= 2'd0;
      target_length <= '0;
      spool_count   <= '0;
      step_count    <= 8'd0;
      idx           <= 3'd0;
      mul_cnt       <= 3'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            cur_mode <= mode;
            idx      <= 3'd0;
            state    <= ST_EMIT;
            case (mode)
              MODE_DISPLAY: mode <= MODE_WAIT;
              MODE_SPOOL: begin
                if (spool_next >= target_length) begin
                  spool_count <= '0;
                  mode        <= MODE_DOWN;
                end else begin
                  spool_count <= spool_next;
                end
              end
              MODE_DOWN: begin
                if (step_next >= down_steps) begin
                  step_count <= 8'd0;
                  mode       <= MODE_UP;
                end else begin
                  step_count <= step_next;
                end
              end
              MODE_UP: begin
                if (step_next >= up_steps) begin
                  step_count <= 8'd0;
                  mode       <= MODE_DISPLAY;
                end else begin
                  step_count <= step_next;
                end
              end
              default: begin
                if (key_code == KEY_STAR) begin
                  // short entry commits a zero length
                  mul_a       <= (digit_count < 2'd2) ? '0 : entry_value;
                  mul_acc     <= '0;
                  mul_b       <= length_scale;
                  mul_cnt     <= 3'd0;
                  digit0      <= CHAR_ZERO;
                  digit1      <= CHAR_ZERO;
                  digit_count <= 2'd0;
                  mode        <= MODE_SPOOL;
                  state       <= ST_MUL;
                end else if (key_code == KEY_HASH) begin
                  digit0      <= CHAR_ZERO;
                  digit1      <= CHAR_ZERO;
                  digit_count <= 2'd0;
                  mode        <= MODE_WAIT;
                end else if (key_code != KEY_NONE) begin
                  if (digit_count < 2'd2) begin
                    if (digit_count[0]) digit1 <= key_code;
                    else digit0 <= key_code;
                    digit_count <= digit_count + 2'd1;
                  end
                  mode <= MODE_DISPLAY;
                end else begin
                  mode <= MODE_WAIT;
                end
              end
            endcase
          end
        end
        ST_MUL: begin
          mul_acc <= acc_next;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == 3'd7) begin
            target_length <= acc_next;
            state         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_take) begin
            if (last) state <= ST_IDLE;
            else idx <= idx + 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_take && last |=> !out_valid)
    else $error("word sent after last of tick");

  a_mul_spool: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> mode == MODE_SPOOL)
    else $error("multiply outside spool commit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while emitting");

  a_idle_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_port == PORT_NONE |-> drive_pattern == 8'h00)
    else $error("pattern on undriven port");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx <= last_idx)
    else $error("word index past end of tick");
`endif

endmodule

`default_nettype wire

[dv/cut_length_stepper_sequencer_tb.sv]
`default_nettype none

module cut_length_stepper_sequencer_tb;
  import cls_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // index past the register list
  localparam int LEN_CAP = 10;              // keeps spool runs short
  localparam int TICKS_PER_PHASE = 55;
  localparam logic [7:0] HALF_STEP [8] = '{8'h01, 8'h03, 8'h02, 8'h06,
                                           8'h04, 8'h0C, 8'h08, 8'h09};

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] pattern;
    logic       show;
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
    logic [2:0] mode;
    logic       last;
  } drive_word_t;

  typedef struct packed {
    logic       cfg;
    logic [1:0] idx;
    logic [7:0] val;
    logic       typed;
    logic [3:0] words;
    logic [1:0] port;
    logic [7:0] pat;
    logic       show;
    logic [2:0] mode;
  } tick_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [7:0] key_code = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] drive_port;
  logic [7:0] drive_pattern;
  logic       show_display;
  logic [1:0] shown_count;
  logic [7:0] shown_first;
  logic [7:0] shown_second;
  logic [2:0] mode_now;
  logic       last;

  cut_length_stepper_sequencer DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .key_code(key_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_port(drive_port), .drive_pattern(drive_pattern),
    .show_display(show_display), .shown_count(shown_count),
    .shown_first(shown_first), .shown_second(shown_second),
    .mode_now(mode_now), .last(last)
  );

  // sequencer shadow state
  logic [7:0] scale_q, down_lim_q, up_lim_q;
  logic [2:0] mode_q;
  logic [7:0] digit_q [2];
  logic [1:0] dcount_q;
  len_t       target_q, spooled_q;
  logic [7:0] steps_q;

  drive_word_t words_due [$];
  tick_row_t   tick_table [$];
  int tick_words;
  int errors = 0, words_seen = 0, ticks_sent = 0, wait_keys = 0;
  int cuts = 0, cfg_writes = 0;
  int send_idle_pct = 7, recv_idle_pct = 55;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s: got %h expected %h", name, got, want));
  endtask

  function automatic int entry_value(input logic [7:0] k1, input logic [7:0] k2);
    logic [7:0] tens, ones;
    tens = k1 - CHAR_ZERO;  // 8-bit wrap on non-digit characters
    ones = k2 - CHAR_ZERO;
    return int'(tens) * 10 + int'(ones);
  endfunction

  function automatic len_t commit_length();
    logic [31:0] prod;
    if (dcount_q < 2) return '0;
    prod = entry_value(digit_q[0], digit_q[1]) * scale_q;
    return prod[LEN_W-1:0];
  endfunction

  function automatic drive_word_t mk_word(input logic [1:0] port, input logic [7:0] pat,
                                          input logic show);
    drive_word_t w;
    w = '0;
    w.port = port;
    w.pattern = pat;
    w.show = show;
    if (show) begin
      w.count = dcount_q;
      w.first = digit_q[0];
      w.second = digit_q[1];
    end
    return w;
  endfunction

  task automatic clear_digits();
    digit_q[0] = CHAR_ZERO;
    digit_q[1] = CHAR_ZERO;
    dcount_q = '0;
  endtask

  task automatic predict_tick(input logic [7:0] key);
    drive_word_t w [8];
    int n;
    n = 0;
    case (mode_q)
      MODE_DISPLAY: begin
        w[0] = mk_word(PORT_NONE, 8'h00, 1'b1);
        n = 1;
      end
      MODE_SPOOL: begin
        w[0] = mk_word(PORT_SPOOL, SPOOL_PAT_A, 1'b0);
        w[1] = mk_word(PORT_SPOOL, SPOOL_PAT_B, 1'b0);
        n = 2;
        spooled_q = spooled_q + 1'b1;
      end
      MODE_DOWN, MODE_UP: begin
        for (int i = 0; i < 8; i++)
          w[i] = mk_word(PORT_BLADE, HALF_STEP[(mode_q == MODE_DOWN) ? i : 7 - i], 1'b0);
        n = 8;
        steps_q = steps_q + 1'b1;
      end
      default: begin
        w[0] = mk_word(PORT_NONE, 8'h00, 1'b0);
        n = 1;
      end
    endcase

    case (mode_q)
      MODE_DISPLAY: mode_q = MODE_WAIT;
      MODE_SPOOL: if (spooled_q >= target_q) begin
        spooled_q = '0;
        mode_q = MODE_DOWN;
      end
      MODE_DOWN: if (steps_q >= down_lim_q) begin
        steps_q = '0;
        mode_q = MODE_UP;
      end
      MODE_UP: if (steps_q >= up_lim_q) begin
        steps_q = '0;
        mode_q = MODE_DISPLAY;
      end
      default: if (key == KEY_STAR) begin
        target_q = commit_length();
        clear_digits();
        mode_q = MODE_SPOOL;
        cuts++;
      end else if (key == KEY_HASH) begin
        clear_digits();
      end else if (key != KEY_NONE) begin
        // a third key is dropped but the display still refreshes
        if (dcount_q < 2) begin
          digit_q[dcount_q[0]] = key;
          dcount_q++;
        end
        mode_q = MODE_DISPLAY;
      end
    endcase

    for (int i = 0; i < n; i++) begin
      w[i].mode = mode_q;
      w[i].last = (i == n - 1);
      words_due.push_back(w[i]);
    end
    tick_words = n;
  endtask

  task automatic hold_until_empty(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_key(input logic [7:0] key);
    logic [7:0] k;
    k = key;
    // long commits would make the run crawl; turn them into a clear
    if (mode_q == MODE_WAIT && k == KEY_STAR && commit_length() > LEN_CAP) k = KEY_HASH;
    if ($urandom_range(0, 63) == 0) hold_until_empty(0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (mode_q == MODE_WAIT) wait_keys++;
    predict_tick(k);
  endtask

  task automatic cfg_store(input logic [1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_LENGTH_SCALE: scale_q = val;
      REG_DOWN_STEPS:   down_lim_q = val;
      REG_UP_STEPS:     up_lim_q = val;
      default: ;
    endcase
  endtask

  task automatic reconfigure(input logic [7:0] s, input logic [7:0] d, input logic [7:0] u);
    hold_until_empty(3);
    cfg_store(REG_LENGTH_SCALE, s);
    cfg_store(REG_DOWN_STEPS, d);
    cfg_store(REG_UP_STEPS, u);
    if ($urandom_range(0, 3) == 0) cfg_store(REG_SPARE, 8'($urandom_range(0, 255)));
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] noise_key();
    return ($urandom_range(0, 1) != 0) ? KEY_NONE : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_digit();
    logic [7:0] k;
    if ($urandom_range(0, 4) != 0) return CHAR_ZERO + 8'($urandom_range(0, 9));
    k = 8'($urandom_range(1, 255));
    if (k == KEY_STAR || k == KEY_HASH) k = CHAR_ZERO;
    return k;
  endfunction

  function automatic logic [7:0] small_limit();
    return 8'($urandom_range(1, 6));
  endfunction

  function automatic logic [7:0] small_scale();
    return 8'($urandom_range(1, 5));
  endfunction

  function automatic tick_row_t key_row(input logic [7:0] key);
    tick_row_t row;
    row = '0;
    row.val = key;
    return row;
  endfunction

  function automatic tick_row_t typed_row(input logic [7:0] key, input int words,
                                          input logic [1:0] port, input logic [7:0] pat,
                                          input logic show, input logic [2:0] mode);
    tick_row_t row;
    row = '0;
    row.val = key;
    row.typed = 1'b1;
    row.words = 4'(words);
    row.port = port;
    row.pat = pat;
    row.show = show;
    row.mode = mode;
    return row;
  endfunction

  function automatic tick_row_t cfg_row(input logic [1:0] idx, input logic [7:0] val);
    tick_row_t row;
    row = '0;
    row.cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  always @(posedge clk) begin : word_check
    drive_word_t got, want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      got = {drive_port, drive_pattern, show_display, shown_count, shown_first,
             shown_second, mode_now, last};
      if (words_due.size() == 0) begin
        report_error($sformatf("word with nothing expected: %h", got));
      end else begin
        want = words_due.pop_front();
        check_field("drive_port", 8'(got.port), 8'(want.port));
        check_field("drive_pattern", got.pattern, want.pattern);
        check_field("show_display", 8'(got.show), 8'(want.show));
        check_field("shown_count", 8'(got.count), 8'(want.count));
        check_field("shown_first", got.first, want.first);
        check_field("shown_second", got.second, want.second);
        check_field("mode_now", 8'(got.mode), 8'(want.mode));
        check_field("last", 8'(got.last), 8'(want.last));
      end
    end
    out_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin : stimulus
    tick_row_t   row;
    drive_word_t fw;
    int base, r, entry_no;
    logic [7:0] k1, k2, kx;

    scale_q = LENGTH_SCALE_RST;
    down_lim_q = DOWN_STEPS_RST;
    up_lim_q = UP_STEPS_RST;
    mode_q = MODE_WAIT;
    clear_digits();
    target_q = '0;
    spooled_q = '0;
    steps_q = '0;

    tick_table = '{
      typed_row(KEY_NONE, 1, PORT_NONE, 8'h00, 1'b0, MODE_WAIT),
      typed_row(KEY_HASH, 1, PORT_NONE, 8'h00, 1'b0, MODE_WAIT),
      typed_row(CHAR_ZERO + 8'd1, 1, PORT_NONE, 8'h00, 1'b0, MODE_DISPLAY),
      typed_row(KEY_NONE, 1, PORT_NONE, 8'h00, 1'b1, MODE_WAIT),
      typed_row(8'hFF, 1, PORT_NONE, 8'h00, 1'b0, MODE_DISPLAY),
      key_row(KEY_STAR),  // ignored on a display tick
      typed_row(CHAR_ZERO + 8'd5, 1, PORT_NONE, 8'h00, 1'b0, MODE_DISPLAY),
      key_row(KEY_HASH),
      typed_row(KEY_HASH, 1, PORT_NONE, 8'h00, 1'b0, MODE_WAIT),
      cfg_row(REG_LENGTH_SCALE, 8'd0),
      cfg_row(REG_DOWN_STEPS, 8'd1),
      cfg_row(REG_UP_STEPS, 8'd1),
      cfg_row(REG_SPARE, 8'hFF),
      key_row(CHAR_ZERO + 8'd9),
      key_row(KEY_NONE),
      key_row(CHAR_ZERO + 8'd9),
      key_row(KEY_NONE),
      typed_row(KEY_STAR, 1, PORT_NONE, 8'h00, 1'b0, MODE_SPOOL),
      typed_row(8'hAA, 2, PORT_SPOOL, SPOOL_PAT_A, 1'b0, MODE_DOWN),
      typed_row(KEY_NONE, 8, PORT_BLADE, 8'h01, 1'b0, MODE_UP),
      typed_row(KEY_NONE, 8, PORT_BLADE, 8'h09, 1'b0, MODE_DISPLAY),
      key_row(KEY_NONE),
      cfg_row(REG_DOWN_STEPS, 8'd0),
      cfg_row(REG_UP_STEPS, 8'd0),
      cfg_row(REG_LENGTH_SCALE, 8'hFF),
      typed_row(KEY_STAR, 1, PORT_NONE, 8'h00, 1'b0, MODE_SPOOL),
      typed_row(KEY_NONE, 2, PORT_SPOOL, SPOOL_PAT_A, 1'b0, MODE_DOWN),
      typed_row(KEY_NONE, 8, PORT_BLADE, 8'h01, 1'b0, MODE_UP),
      typed_row(KEY_NONE, 8, PORT_BLADE, 8'h09, 1'b0, MODE_DISPLAY),
      key_row(KEY_NONE),
      key_row(CHAR_ZERO + 8'd7),
      key_row(KEY_NONE),
      typed_row(KEY_STAR, 1, PORT_NONE, 8'h00, 1'b0, MODE_SPOOL)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (tick_table[i]) begin
      row = tick_table[i];
      if (row.cfg) begin
        if (!cfg_write) hold_until_empty(3);
        cfg_store(row.idx, row.val);
      end else begin
        if (cfg_write) cfg_write <= 1'b0;
        send_key(row.val);
        if (row.typed) begin
          fw = words_due[words_due.size() - tick_words];
          if (tick_words != int'(row.words) || fw.port != row.port || fw.pattern != row.pat ||
              fw.show != row.show || fw.mode != row.mode)
            report_error($sformatf("directed row %0d: table and prediction disagree", i));
        end
      end
    end

    base = ticks_sent;
    entry_no = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 7;  recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (ticks_sent < base + TICKS_PER_PHASE * (ph + 1)) begin
        // run out any cut in progress; keys are ignored meanwhile
        while (mode_q != MODE_WAIT) send_key(noise_key());

        if (entry_no == 0) begin
          reconfigure(8'd1, small_limit(), small_limit());
        end else if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 7))
            0: reconfigure(8'($urandom_range(6, 255)), small_limit(), small_limit());
            1: reconfigure(8'd0, small_limit(), small_limit());
            2: reconfigure(small_scale(), 8'd1, small_limit());
            3: reconfigure(small_scale(), small_limit(), 8'd1);
            4: reconfigure(small_scale(), 8'd0, 8'd0);
            default: reconfigure(small_scale(), small_limit(), small_limit());
          endcase
        end
        entry_no++;

        r = $urandom_range(0, 9);
        if (r < 6) begin
          if ($urandom_range(0, 3) == 0) send_key(KEY_HASH);
          k1 = pick_digit();
          k2 = pick_digit();
          for (int t = 0; t < 12; t++) begin
            if (entry_value(k1, k2) * scale_q <= LEN_CAP) break;
            k1 = (t >= 4) ? CHAR_ZERO : pick_digit();
            k2 = pick_digit();
          end
          send_key(k1);
          send_key(noise_key());
          send_key(k2);
          send_key(noise_key());
          if ($urandom_range(0, 4) == 0) begin
            send_key(pick_digit());
            send_key(noise_key());
          end
          send_key(KEY_STAR);
        end else if (r < 8) begin
          // short entry: none or one digit before the commit
          send_key(KEY_HASH);
          if ($urandom_range(0, 1) != 0) begin
            send_key(pick_digit());
            send_key(noise_key());
          end
          send_key(KEY_STAR);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0: kx = KEY_NONE;
              1: kx = KEY_HASH;
              2: kx = pick_digit();
              default: kx = 8'($urandom_range(0, 255));
            endcase
            send_key(kx);
          end
          if ($urandom_range(0, 1) != 0) send_key(KEY_STAR);
        end
      end
    end

    hold_until_empty(16);
    $display("Ran %0d ticks (%0d keyed in wait), %0d cut cycles, %0d register writes",
             ticks_sent, wait_keys, cuts, cfg_writes);
    $display("Checked %0d drive words, %0d mismatches", words_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("ERROR: timeout with %0d words still expected", words_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
